// ----- src/ctnc_pkg.sv -----
// ----------------------------------------------------------------------------
// ctnc_pkg
// Shared widths, vertex type and controller command/status structs.
// ----------------------------------------------------------------------------
package ctnc_pkg;

   localparam int COORD_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int RGB_BITS   = 24;
   localparam int QBITS      = COORD_BITS + FRAC_BITS;
   localparam int DIV_STEPS  = QBITS;
   localparam int STEP_BITS  = $clog2(DIV_STEPS + 1);
   localparam int REQ_BYTES  = (4 * COORD_BITS + RGB_BITS + 7) / 8;
   localparam int RSP_BYTES  = (4 * COORD_BITS + RGB_BITS + 7) / 8;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      coord_type w;
      logic [RGB_BITS-1:0] rgb;
   } vtx_type;

   // output source selection codes
   localparam logic [2:0] SRC_V0 = 3'd0;
   localparam logic [2:0] SRC_V1 = 3'd1;
   localparam logic [2:0] SRC_V2 = 3'd2;
   localparam logic [2:0] SRC_C1 = 3'd3;
   localparam logic [2:0] SRC_C2 = 3'd4;

   typedef struct packed {
      logic       hold0;     // capture input into held slot 0
      logic       hold1;     // capture input into held slot 1
      logic       hold2;     // capture input as third vertex
      logic       clip_go;   // start one interpolation
      logic [1:0] clip_out;  // outside vertex index
      logic [1:0] clip_in;   // inside vertex index
      logic       clip_dst;  // 0: result to C1, 1: to C2
      logic [2:0] src;       // vertex driven to the output register
      logic       emit;      // load output register
   } cmd_type;

   typedef struct packed {
      logic       clip_busy;
      logic       reject;
      logic [2:0] near_out;
   } sts_type;

endpackage

// ----- src/ctnc_datapath.sv -----
// ----------------------------------------------------------------------------
// ctnc_datapath
// Vertex store, plane tests, serial divider, component scaler, output stage.
// ----------------------------------------------------------------------------
module ctnc_datapath (
   input  logic                clock,
   input  logic                reset,
   input  ctnc_pkg::vtx_type   in_vtx,
   input  ctnc_pkg::cmd_type   cmd,
   output ctnc_pkg::sts_type   sts,
   output ctnc_pkg::vtx_type   out_vtx
);
   import ctnc_pkg::*;

   localparam logic [2:0] CS_IDLE = 3'd0;
   localparam logic [2:0] CS_DIV  = 3'd1;
   localparam logic [2:0] CS_MUL  = 3'd2;
   localparam logic [2:0] CS_ADD  = 3'd3;
   localparam logic [2:0] CS_PRD  = 3'd4;

   localparam logic signed [COORD_BITS+1:0] CMAX_X =
      (COORD_BITS+2)'((65'sd1 <<< (COORD_BITS-1)) - 65'sd1);
   localparam logic signed [COORD_BITS+1:0] CMIN_X = -CMAX_X - 1;

   vtx_type v0_ff, v1_ff, v2_ff, c1_ff, c2_ff;
   vtx_type o_ff, i_ff;
   logic    dst_ff;

   logic [2:0]           cs_ff, cs_in;
   logic [STEP_BITS-1:0] step_ff;
   logic [QBITS-1:0]     q_ff, n_ff;
   logic [COORD_BITS:0]  r_ff, d_ff;
   logic                 neg_ff;
   coord_type            t_ff;
   logic [1:0]           k_ff;
   logic signed [COORD_BITS:0]     diff_ff;
   logic signed [2*COORD_BITS+1:0] prod_ff;
   coord_type            res_ff [4];

   function automatic vtx_type pick(input logic [1:0] s, input vtx_type a,
                                    input vtx_type b, input vtx_type c);
      case (s)
         2'd0:    pick = a;
         2'd1:    pick = b;
         default: pick = c;
      endcase
   endfunction

   function automatic coord_type comp(input vtx_type v, input logic [1:0] k);
      case (k)
         2'd0:    comp = v.x;
         2'd1:    comp = v.y;
         2'd2:    comp = v.z;
         default: comp = v.w;
      endcase
   endfunction

   // plane tests
   logic [2:0] nr, fr, lf, rt, bt, tp;
   always_comb begin
      vtx_type v;
      logic signed [COORD_BITS:0] nw;
      for (int k = 0; k < 3; k++) begin
         v  = (k == 0) ? v0_ff : (k == 1) ? v1_ff : v2_ff;
         nw = -(COORD_BITS+1)'(v.w);
         nr[k] = (COORD_BITS+1)'(v.z) < nw;
         fr[k] = v.z > v.w;
         lf[k] = (COORD_BITS+1)'(v.x) < nw;
         rt[k] = v.x > v.w;
         bt[k] = (COORD_BITS+1)'(v.y) < nw;
         tp[k] = v.y > v.w;
      end
   end
   assign sts.near_out  = nr;
   assign sts.reject    = (&nr) | (&fr) | (&lf) | (&rt) | (&bt) | (&tp);
   assign sts.clip_busy = (cs_ff != CS_IDLE);

   always_ff @(posedge clock) begin
      if (cmd.hold0) v0_ff <= in_vtx;
      if (cmd.hold1) v1_ff <= in_vtx;
      if (cmd.hold2) v2_ff <= in_vtx;
   end

   // signed divider numerator and denominator
   logic signed [COORD_BITS:0] num_s, den_s;
   vtx_type oa, ia;
   always_comb begin
      oa = pick(cmd.clip_out, v0_ff, v1_ff, v2_ff);
      ia = pick(cmd.clip_in,  v0_ff, v1_ff, v2_ff);
      num_s = -(COORD_BITS+1)'(oa.z);
      den_s = (COORD_BITS+1)'(ia.z) - (COORD_BITS+1)'(oa.z);
   end

   logic [COORD_BITS:0] r_sh, r_sub;
   logic                r_ge;
   always_comb begin
      r_sh  = {r_ff[COORD_BITS-1:0], n_ff[QBITS-1]};
      r_ge  = ({1'b0, r_ff} << 1 | (COORD_BITS+2)'(n_ff[QBITS-1])) >=
              (COORD_BITS+2)'(d_ff);
      r_sub = r_sh - d_ff;
   end

   // saturation limits
   logic [QBITS-1:0] lim_q;
   assign lim_q = neg_ff ? QBITS'(CMAX_X) + 1'b1 : QBITS'(CMAX_X);

   logic [2*COORD_BITS+1:0] pmag;
   logic [2*COORD_BITS+1:0] psh;
   logic signed [COORD_BITS+1:0] scl, sum;
   logic pneg;
   always_comb begin
      pneg = prod_ff[2*COORD_BITS+1];
      pmag = pneg ? -prod_ff : prod_ff;
      psh  = pmag >> FRAC_BITS;
      if (psh > (2*COORD_BITS+2)'(CMAX_X) + (pneg ? 1 : 0))
         scl = pneg ? CMIN_X : CMAX_X;
      else
         scl = pneg ? -(COORD_BITS+2)'(psh) : (COORD_BITS+2)'(psh);
      sum = (COORD_BITS+2)'(comp(o_ff, k_ff)) + scl;
      if (sum > CMAX_X)      sum = CMAX_X;
      else if (sum < CMIN_X) sum = CMIN_X;
   end

   always_comb begin
      cs_in = cs_ff;
      case (cs_ff)
         CS_IDLE: if (cmd.clip_go) cs_in = CS_DIV;
         CS_DIV:  if (step_ff == STEP_BITS'(0)) cs_in = CS_MUL;
         CS_MUL:  cs_in = CS_PRD;
         CS_PRD:  cs_in = CS_ADD;
         CS_ADD:  cs_in = (k_ff == 2'd3) ? CS_IDLE : CS_MUL;
         default: cs_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) cs_ff <= CS_IDLE;
      else       cs_ff <= cs_in;
   end

   always_ff @(posedge clock) begin
      case (cs_ff)
         CS_IDLE: if (cmd.clip_go) begin
            o_ff    <= oa;
            i_ff    <= ia;
            dst_ff  <= cmd.clip_dst;
            neg_ff  <= num_s[COORD_BITS] ^ den_s[COORD_BITS];
            n_ff    <= QBITS'({(num_s[COORD_BITS] ? -num_s : num_s),
                               {FRAC_BITS{1'b0}}});
            d_ff    <= den_s[COORD_BITS] ? -den_s : den_s;
            r_ff    <= '0;
            q_ff    <= '0;
            step_ff <= STEP_BITS'(DIV_STEPS);
            k_ff    <= 2'd0;
         end
         CS_DIV: begin
            if (step_ff != STEP_BITS'(0)) begin
               n_ff    <= n_ff << 1;
               r_ff    <= r_ge ? r_sub : r_sh;
               q_ff    <= {q_ff[QBITS-2:0], r_ge};
               step_ff <= step_ff - 1'b1;
            end else begin
               if (o_ff.z == '0)       t_ff <= '0;
               else if (d_ff == '0)    t_ff <= neg_ff ? coord_type'(CMIN_X)
                                                      : coord_type'(CMAX_X);
               else if (q_ff > lim_q)  t_ff <= neg_ff ? coord_type'(CMIN_X)
                                                      : coord_type'(CMAX_X);
               else t_ff <= neg_ff ? -coord_type'(q_ff) : coord_type'(q_ff);
            end
         end
         CS_MUL: begin
            diff_ff <= (COORD_BITS+1)'(comp(i_ff, k_ff))
                       - (COORD_BITS+1)'(comp(o_ff, k_ff));
         end
         CS_ADD: begin
            res_ff[k_ff] <= coord_type'(sum);
            k_ff <= k_ff + 1'b1;
            if (k_ff == 2'd3) begin
               if (dst_ff) c2_ff <= {res_ff[0], res_ff[1], res_ff[2],
                                     coord_type'(sum), o_ff.rgb};
               else        c1_ff <= {res_ff[0], res_ff[1], res_ff[2],
                                     coord_type'(sum), o_ff.rgb};
            end
         end
         default: ;
      endcase
   end

   // product registered in the PRD cycle, consumed in ADD
   always_ff @(posedge clock) begin
      prod_ff <= (2*COORD_BITS+2)'(diff_ff) * (2*COORD_BITS+2)'(t_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         case (cmd.src)
            SRC_V0:  out_vtx <= v0_ff;
            SRC_V1:  out_vtx <= v1_ff;
            SRC_V2:  out_vtx <= v2_ff;
            SRC_C1:  out_vtx <= c1_ff;
            default: out_vtx <= c2_ff;
         endcase
      end
   end

endmodule

// ----- src/ctnc_control.sv -----
// ----------------------------------------------------------------------------
// ctnc_control
// Vertex slot counter, clip sequencing and emit sequencing.
// ----------------------------------------------------------------------------
module ctnc_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   output logic               out_valid,
   input  logic               out_ready,
   output logic               out_last,
   input  ctnc_pkg::sts_type  sts,
   output ctnc_pkg::cmd_type  cmd
);
   import ctnc_pkg::*;

   localparam logic [2:0] ST_IN   = 3'd0;
   localparam logic [2:0] ST_TEST = 3'd1;
   localparam logic [2:0] ST_CLIP = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [1:0] slot_ff, slot_in;
   logic [2:0] idx_ff, idx_in;
   logic [2:0] cnt_ff, cnt_in;   // number of vertices to emit
   logic       nclip_ff, nclip_in; // clips done
   logic       valid_ff, valid_in, last_ff, last_in;
   logic [1:0] o1, o2, ii;       // role indices
   logic       two_ff, two_in;

   // roles from near flags
   always_comb begin
      two_in = 1'b0; o1 = 2'd0; o2 = 2'd1; ii = 2'd2;
      if (sts.near_out[0] && sts.near_out[1]) begin
         two_in = 1'b1; o1 = 2'd0; o2 = 2'd1; ii = 2'd2;
      end else if (sts.near_out[1] && sts.near_out[2]) begin
         two_in = 1'b1; o1 = 2'd1; o2 = 2'd2; ii = 2'd0;
      end else if (sts.near_out[0] && sts.near_out[2]) begin
         two_in = 1'b1; o1 = 2'd2; o2 = 2'd0; ii = 2'd1;
      end else if (sts.near_out[0]) begin
         o1 = 2'd0; o2 = 2'd1; ii = 2'd2;
      end else if (sts.near_out[1]) begin
         o1 = 2'd1; o2 = 2'd2; ii = 2'd0;
      end else begin
         o1 = 2'd2; o2 = 2'd0; ii = 2'd1;
      end
   end

   logic [2:0] src_sel;
   always_comb begin
      src_sel = SRC_V0;
      if (sts.near_out == 3'b000) begin
         src_sel = (idx_ff == 3'd0) ? SRC_V0 : (idx_ff == 3'd1) ? SRC_V1 : SRC_V2;
      end else if (two_ff) begin
         case (idx_ff)
            3'd0:    src_sel = {1'b0, ii};
            3'd1:    src_sel = SRC_C1;
            default: src_sel = SRC_C2;
         endcase
      end else begin
         case (idx_ff)
            3'd0:    src_sel = {1'b0, o2};
            3'd1:    src_sel = {1'b0, ii};
            3'd2:    src_sel = SRC_C2;
            3'd3:    src_sel = {1'b0, o2};
            3'd4:    src_sel = SRC_C2;
            default: src_sel = SRC_C1;
         endcase
      end
   end

   logic out_free;
   assign out_free = !valid_ff || out_ready;

   always_comb begin
      state_in = state_ff; slot_in = slot_ff; idx_in = idx_ff; cnt_in = cnt_ff;
      nclip_in = nclip_ff; valid_in = valid_ff && !out_ready; last_in = last_ff;
      cmd = '0;
      cmd.src = src_sel;
      in_ready = (state_ff == ST_IN);
      case (state_ff)
         ST_IN: if (in_valid) begin
            case (slot_ff)
               2'd0:    begin cmd.hold0 = 1'b1; slot_in = 2'd1; end
               2'd1:    begin cmd.hold1 = 1'b1; slot_in = 2'd2; end
               default: begin cmd.hold2 = 1'b1; slot_in = 2'd0; state_in = ST_TEST; end
            endcase
         end
         ST_TEST: begin
            idx_in = 3'd0; nclip_in = 1'b0;
            if (sts.reject)                  state_in = ST_IN;
            else if (sts.near_out == 3'b000) begin cnt_in = 3'd3; state_in = ST_EMIT; end
            else begin cnt_in = two_in ? 3'd3 : 3'd6; state_in = ST_CLIP; end
         end
         ST_CLIP: begin
            cmd.clip_go = 1'b1;
            // clip 0 -> C1, clip 1 -> C2
            if (two_ff) begin
               cmd.clip_out = nclip_ff ? o2 : o1; cmd.clip_in = ii;
            end else begin
               cmd.clip_out = o1; cmd.clip_in = nclip_ff ? ii : o2;
            end
            cmd.clip_dst = nclip_ff;
            state_in = ST_WAIT;
         end
         ST_WAIT: if (!sts.clip_busy) begin
            nclip_in = 1'b1;
            state_in = nclip_ff ? ST_EMIT : ST_CLIP;
         end
         ST_EMIT: if (out_free) begin
            cmd.emit = 1'b1;
            valid_in = 1'b1;
            last_in  = (idx_ff == cnt_ff - 3'd1);
            idx_in   = idx_ff + 3'd1;
            if (idx_ff == cnt_ff - 3'd1) state_in = ST_IN;
         end
         default: state_in = ST_IN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IN; slot_ff <= 2'd0; idx_ff <= 3'd0; cnt_ff <= 3'd0;
         nclip_ff <= 1'b0; valid_ff <= 1'b0; last_ff <= 1'b0; two_ff <= 1'b0;
      end else begin
         state_ff <= state_in; slot_ff <= slot_in; idx_ff <= idx_in; cnt_ff <= cnt_in;
         nclip_ff <= nclip_in; valid_ff <= valid_in; last_ff <= last_in;
         if (state_ff == ST_TEST) two_ff <= two_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_last  = last_ff;

   a_slot: assert property (@(posedge clock) disable iff (reset) slot_ff != 2'd3)
      else $error("slot out of range");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free) else $error("output overwritten");
   a_clip_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.clip_go |-> !sts.clip_busy) else $error("clip started while busy");
   a_no_in_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IN) |-> !in_ready) else $error("input taken while busy");

endmodule

// ----- src/clip_space_triangle_near_clipper.sv -----
// ----------------------------------------------------------------------------
// clip_space_triangle_near_clipper
// Frustum cull and near-plane clip of clip-space triangles.
// ----------------------------------------------------------------------------
// Vertices arrive one per transaction; every third completes a triangle.
// A completed triangle goes through the plane tests, and is either dropped,
// emitted as three vertices, or clipped. Each clip vertex is launched, passes
// through a 48-step restoring divider (a final step applies the saturation),
// then four multiply/saturate passes (difference, product, shift and add),
// and the controller then waits to see it complete. A clipped triangle gives
// two new vertices. Results leave through one output register at one per
// cycle while the sink accepts; the input is held off until the last vertex
// of the triangle has been loaded into that register.
// ----------------------------------------------------------------------------
module clip_space_triangle_near_clipper (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x[31:0], pos_y[63:32], pos_z[95:64], pos_w[127:96], rgb[151:128]
   input  logic [ctnc_pkg::REQ_BYTES*8-1:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96], out_rgb[151:128]
   output logic [ctnc_pkg::RSP_BYTES*8-1:0] rsp_tdata,
   output logic         rsp_tlast
);
   import ctnc_pkg::*;

   vtx_type in_vtx, out_vtx;
   cmd_type cmd;
   sts_type sts;

   // unpack: first field lowest
   assign in_vtx.x   = req_tdata[COORD_BITS-1:0];
   assign in_vtx.y   = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign in_vtx.z   = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign in_vtx.w   = req_tdata[4*COORD_BITS-1:3*COORD_BITS];
   assign in_vtx.rgb = req_tdata[4*COORD_BITS+RGB_BITS-1:4*COORD_BITS];

   assign rsp_tdata = (RSP_BYTES*8)'({out_vtx.rgb, out_vtx.w, out_vtx.z,
                                      out_vtx.y, out_vtx.x});

   ctnc_control u_ctl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_last(rsp_tlast),
      .sts(sts), .cmd(cmd)
   );

   ctnc_datapath u_dp (
      .clock(clock), .reset(reset),
      .in_vtx(in_vtx), .cmd(cmd), .sts(sts), .out_vtx(out_vtx)
   );

endmodule

// ----- dv/clip_space_triangle_near_clipper_tb.sv -----
// ----------------------------------------------------------------------------
// clip_space_triangle_near_clipper_tb
// Self-checking bench for the triangle cull and near-plane clipper.
// ----------------------------------------------------------------------------
// Vertices are streamed in groups of three. A scoreboard class holds its own
// model of the block: the two held vertices and the slot counter. On every
// third accepted vertex it predicts the triangle's output: nothing, three
// vertices, or six. Each accepted output transaction is checked field by
// field against the oldest prediction. Four traffic phases vary the idling
// on both sides. A watchdog ends the run if nothing moves for too long.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clip_space_triangle_near_clipper_tb;
   import ctnc_pkg::*;

   localparam longint CRD_MAX   = (64'sd1 <<< (COORD_BITS - 1)) - 1;
   localparam longint CRD_MIN   = -CRD_MAX - 1;
   localparam int     WDOG_LIMIT = 20000;

   typedef struct {
      longint c[4];
      logic [RGB_BITS-1:0] rgb;
   } vert_type;

   typedef struct packed {
      coord_type x, y, z, w;
      logic [RGB_BITS-1:0] rgb;
      logic last;
   } emitted_vertex_type;

   // ------------------------------------------------------------------------
   // Scoreboard: triangle model plus the queue of expected output vertices
   // ------------------------------------------------------------------------
   class triangle_scoreboard;
      vert_type           held[2];
      int                 slot;
      emitted_vertex_type expected_vertices[$];
      int                 mismatches;

      function new();
         slot       = 0;
         mismatches = 0;
      endfunction

      function longint clamp(longint v);
         if (v > CRD_MAX) return CRD_MAX;
         if (v < CRD_MIN) return CRD_MIN;
         return v;
      endfunction

      // fixed-point quotient with magnitude truncation and saturation
      function longint quotient(longint num, longint den);
         bit          neg;
         logic [63:0] n, d, lim, q;
         neg = (num < 0) != (den < 0);
         n   = (num < 0) ? -num : num;
         d   = (den < 0) ? -den : den;
         lim = neg ? CRD_MAX + 1 : CRD_MAX;
         if (n == 0) return 0;
         if (d == 0) return neg ? CRD_MIN : CRD_MAX;
         if (n / d > (lim >> FRAC_BITS)) return neg ? -longint'(lim) : longint'(lim);
         q = (n << FRAC_BITS) / d;
         if (q > lim) q = lim;
         return neg ? -longint'(q) : longint'(q);
      endfunction

      // exact product shifted down, magnitude truncated, saturated
      function longint scaled(longint diff, longint t);
         bit           neg;
         logic [127:0] a, b, p;
         logic [63:0]  lim;
         neg = (diff < 0) != (t < 0);
         a   = (diff < 0) ? -diff : diff;
         b   = (t < 0) ? -t : t;
         p   = (a * b) >> FRAC_BITS;
         lim = neg ? CRD_MAX + 1 : CRD_MAX;
         if (p > {64'd0, lim}) p = {64'd0, lim};
         return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
      endfunction

      function vert_type clip_edge(vert_type o, vert_type i);
         vert_type r;
         longint   t;
         t = quotient(-o.c[2], i.c[2] - o.c[2]);
         for (int k = 0; k < 4; k++)
            r.c[k] = clamp(o.c[k] + scaled(i.c[k] - o.c[k], t));
         r.rgb = o.rgb;
         return r;
      endfunction

      function void push(vert_type v, bit last);
         emitted_vertex_type e;
         e.x = coord_type'(v.c[0]);
         e.y = coord_type'(v.c[1]);
         e.z = coord_type'(v.c[2]);
         e.w = coord_type'(v.c[3]);
         e.rgb  = v.rgb;
         e.last = last;
         expected_vertices = {expected_vertices, e};
      endfunction

      function void two_outside(vert_type o1, vert_type o2, vert_type i);
         vert_type c1, c2;
         c1 = clip_edge(o1, i);
         c2 = clip_edge(o2, i);
         push(i, 0); push(c1, 0); push(c2, 1);
      endfunction

      function void one_outside(vert_type o, vert_type i1, vert_type i2);
         vert_type c1, c2;
         c1 = clip_edge(o, i1);
         c2 = clip_edge(o, i2);
         push(i1, 0); push(i2, 0); push(c2, 0);
         push(i1, 0); push(c2, 0); push(c1, 1);
      endfunction

      function void predict_triangle(vert_type v[3]);
         bit n[3], f[3], l[3], r[3], b[3], t[3];
         for (int k = 0; k < 3; k++) begin
            n[k] = v[k].c[2] < -v[k].c[3];
            f[k] = v[k].c[2] >  v[k].c[3];
            l[k] = v[k].c[0] < -v[k].c[3];
            r[k] = v[k].c[0] >  v[k].c[3];
            b[k] = v[k].c[1] < -v[k].c[3];
            t[k] = v[k].c[1] >  v[k].c[3];
         end
         if ((n[0] & n[1] & n[2]) | (f[0] & f[1] & f[2]) | (l[0] & l[1] & l[2]) |
             (r[0] & r[1] & r[2]) | (b[0] & b[1] & b[2]) | (t[0] & t[1] & t[2]))
            return;
         if (!n[0] && !n[1] && !n[2]) begin
            push(v[0], 0); push(v[1], 0); push(v[2], 1);
         end else if (n[0] && n[1]) two_outside(v[0], v[1], v[2]);
         else if (n[1] && n[2]) two_outside(v[1], v[2], v[0]);
         else if (n[0] && n[2]) two_outside(v[2], v[0], v[1]);
         else if (n[0]) one_outside(v[0], v[1], v[2]);
         else if (n[1]) one_outside(v[1], v[2], v[0]);
         else one_outside(v[2], v[0], v[1]);
      endfunction

      function void note_vertex(vtx_type in);
         vert_type v;
         vert_type corners[3];
         v.c[0] = longint'(in.x);
         v.c[1] = longint'(in.y);
         v.c[2] = longint'(in.z);
         v.c[3] = longint'(in.w);
         v.rgb  = in.rgb;
         if (slot < 2) begin
            held[slot] = v;
            slot++;
         end else begin
            corners[0] = held[0];
            corners[1] = held[1];
            corners[2] = v;
            slot = 0;
            predict_triangle(corners);
         end
      endfunction

      function void check_vertex(emitted_vertex_type got);
         emitted_vertex_type exp;
         if (expected_vertices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected output vertex x=%h y=%h z=%h w=%h rgb=%h last=%b",
                        got.x, got.y, got.z, got.w, got.rgb, got.last);
            return;
         end
         exp = expected_vertices.pop_front();
         if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("vertex mismatch: exp x=%h y=%h z=%h w=%h rgb=%h last=%b",
                        exp.x, exp.y, exp.z, exp.w, exp.rgb, exp.last);
               $display("                 got x=%h y=%h z=%h w=%h rgb=%h last=%b",
                        got.x, got.y, got.z, got.w, got.rgb, got.last);
            end
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // DUT and clocking
   // ------------------------------------------------------------------------
   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_tvalid = 0;
   logic                     req_tready;
   logic [REQ_BYTES*8-1:0]   req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 0;
   logic [RSP_BYTES*8-1:0]   rsp_tdata;
   logic                     rsp_tlast;

   triangle_scoreboard board;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  idle_cycles = 0;
   bit  timed_out = 0;

   always #10 clock = ~clock;

   clip_space_triangle_near_clipper u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // pack a vertex into tdata: x lowest, then y, z, w, colour
   function automatic logic [REQ_BYTES*8-1:0] pack_vertex(vtx_type v);
      logic [REQ_BYTES*8-1:0] d;
      d = '0;
      d[0 +: COORD_BITS]                = v.x;
      d[COORD_BITS +: COORD_BITS]       = v.y;
      d[2*COORD_BITS +: COORD_BITS]     = v.z;
      d[3*COORD_BITS +: COORD_BITS]     = v.w;
      d[4*COORD_BITS +: RGB_BITS]       = v.rgb;
      return d;
   endfunction

   // Sink side: stall at random, check each accepted output transaction
   always @(posedge clock) begin
      emitted_vertex_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.x    = rsp_tdata[0 +: COORD_BITS];
            got.y    = rsp_tdata[COORD_BITS +: COORD_BITS];
            got.z    = rsp_tdata[2*COORD_BITS +: COORD_BITS];
            got.w    = rsp_tdata[3*COORD_BITS +: COORD_BITS];
            got.rgb  = rsp_tdata[4*COORD_BITS +: RGB_BITS];
            got.last = rsp_tlast;
            board.check_vertex(got);
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: count cycles in which no transaction is accepted on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("status: fail");
         $finish;
      end
   end

   // Drive one vertex and hold it until accepted; idle first at random
   task automatic send_vertex(vtx_type v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pack_vertex(v);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_vertex(v);
   endtask

   // Drop valid before waiting on the sink
   task automatic release_input();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(5))
         0: return coord_type'($urandom());
         1: return coord_type'(CRD_MAX);
         2: return coord_type'(CRD_MIN);
         default: return coord_type'(int'($urandom_range(8 << 16)) - (4 << 16));
      endcase
   endfunction

   function automatic vtx_type mk(coord_type x, coord_type y, coord_type z, coord_type w,
                                  logic [RGB_BITS-1:0] rgb);
      vtx_type v;
      v.x = x; v.y = y; v.z = z; v.w = w; v.rgb = rgb;
      return v;
   endfunction

   // random vertex, mostly inside the frustum, sometimes beyond near
   function automatic vtx_type rand_vertex(bit beyond_near);
      vtx_type v;
      coord_type w;
      w = coord_type'($urandom_range(4 << 16, 1 << 16));
      v.x = ($urandom_range(3) == 0) ? rand_coord() : coord_type'(int'($urandom_range(2*w)) - w);
      v.y = ($urandom_range(3) == 0) ? rand_coord() : coord_type'(int'($urandom_range(2*w)) - w);
      v.w = ($urandom_range(7) == 0) ? rand_coord() : w;
      v.z = beyond_near ? coord_type'(-int'(w) - int'($urandom_range(3 << 16, 1)))
                        : coord_type'(int'($urandom_range(2*w)) - w);
      if ($urandom_range(9) == 0) v.z = rand_coord();
      v.rgb = RGB_BITS'($urandom());
      return v;
   endfunction

   localparam coord_type ONE = coord_type'(1 << 16);

   initial begin
      int phase_idle[4];
      int phase_stall[4];
      board = new();
      phase_idle  = '{0, 74, 0, 36};
      phase_stall = '{0, 0, 74, 36};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: pass-through, near, far, left and top culls, one and two beyond
      // near, zero numerator, zero divisor, extreme values
      send_vertex(mk(0, 0, 0, ONE, 24'h000000));
      send_vertex(mk(ONE, 0, 0, ONE, 24'hFFFFFF));
      send_vertex(mk(0, ONE, 0, ONE, 24'h123456));
      // all beyond near
      for (int k = 0; k < 3; k++) send_vertex(mk(0, 0, -3*ONE, ONE, 24'hA5A5A5));
      // all beyond far
      for (int k = 0; k < 3; k++) send_vertex(mk(0, 0, 3*ONE, ONE, 24'h5A5A5A));
      // all left, then all top
      for (int k = 0; k < 3; k++) send_vertex(mk(-3*ONE, 0, 0, ONE, 24'h0F0F0F));
      for (int k = 0; k < 3; k++) send_vertex(mk(0, 3*ONE, 0, ONE, 24'hF0F0F0));
      // one beyond near
      send_vertex(mk(ONE, -ONE, -2*ONE, ONE, 24'hFF0000));
      send_vertex(mk(0, ONE, 0, ONE, 24'h00FF00));
      send_vertex(mk(-ONE, 0, ONE/2, ONE, 24'h0000FF));
      // two beyond near: one with zero divisor (same z as the inside vertex),
      // one with extreme values
      send_vertex(mk(0, 0, -ONE, 2*ONE, 24'h111111));
      send_vertex(mk(coord_type'(CRD_MAX), coord_type'(CRD_MIN), -ONE, 0, 24'h222222));
      send_vertex(mk(coord_type'(CRD_MIN), coord_type'(CRD_MAX), coord_type'(CRD_MIN), 0,
                     24'h333333));
      // zero numerator: outside vertex with z = 0 and negative w
      send_vertex(mk(0, 0, 0, -ONE, 24'h444444));
      send_vertex(mk(0, 0, 0, -ONE, 24'h555555));
      send_vertex(mk(ONE, ONE, ONE, 2*ONE, 24'h666666));

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = phase_idle[ph];
         recv_stall_pct = phase_stall[ph];
         for (int tri_n = 0; tri_n < 13; tri_n++) begin
            int shape;
            shape = $urandom_range(7);
            for (int k = 0; k < 3; k++) begin
               if (shape == 7)
                  send_vertex(mk(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                 RGB_BITS'($urandom())));
               else
                  send_vertex(rand_vertex((shape >= 2) && ($urandom_range(2) == 0)));
            end
         end
         // drain before the next traffic phase
         release_input();
         while (board.expected_vertices.size() != 0) @(posedge clock);
      end

      recv_stall_pct = 0;
      while (board.expected_vertices.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (board.mismatches == 0 && board.expected_vertices.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
src/ctnc_pkg.sv
src/ctnc_datapath.sv
src/ctnc_control.sv
src/clip_space_triangle_near_clipper.sv
dv/clip_space_triangle_near_clipper_tb.sv
